// ===== design/ifmt_pkg.sv =====
// ----------------------------------------------------------------------------
// ifmt_pkg
// Shared constants for the IPv4 five-tuple flow metering table.
// ----------------------------------------------------------------------------
package ifmt_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;

    // Stream widths
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned TIME_W      = 64;
    localparam int unsigned CNT_W       = 64;
    localparam int unsigned SLOT_W      = 10;
    localparam int unsigned IN_TDATA_W  = 72;   // frame_byte + now_ns
    localparam int unsigned OUT_TDATA_W = 208;  // slot + three counters, padded
    localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - SLOT_W - 3 * CNT_W;
    localparam int unsigned OUTCOME_W   = 2;

    // Frame header fields
    localparam int unsigned POS_W     = 6;
    localparam int unsigned ETYPE_W   = 16;
    localparam int unsigned IPLEN_W   = 16;
    localparam int unsigned PROTO_W   = 8;
    localparam int unsigned ADDR_W    = 64;
    localparam int unsigned PORTS_W   = 32;
    localparam int unsigned KEY_W     = ADDR_W + PORTS_W + PROTO_W;
    localparam int unsigned CNTRS_W   = 3 * CNT_W;

    // Byte offsets within the frame
    localparam logic [POS_W-1:0] POS_ETYPE_HI = 6'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO = 6'd13;
    localparam logic [POS_W-1:0] POS_IPLEN_HI = 6'd16;
    localparam logic [POS_W-1:0] POS_IPLEN_LO = 6'd17;
    localparam logic [POS_W-1:0] POS_PROTO    = 6'd23;
    localparam logic [POS_W-1:0] POS_ADDR_FST = 6'd26;
    localparam logic [POS_W-1:0] POS_ADDR_LST = 6'd33;
    localparam logic [POS_W-1:0] POS_PORT_FST = 6'd34;
    localparam logic [POS_W-1:0] POS_PORT_LST = 6'd37;
    localparam logic [POS_W-1:0] POS_MAX      = 6'd63;

    localparam logic [POS_W-1:0] MIN_IP_LEN  = 6'd34;
    localparam logic [POS_W-1:0] MIN_TCP_LEN = 6'd54;
    localparam logic [POS_W-1:0] MIN_UDP_LEN = 6'd42;

    localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [PROTO_W-1:0] PROTO_TCP      = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP      = 8'd17;

    // Outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_NONE   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_UPDATE = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_INSERT = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_FULL   = 2'd3;

endpackage

// ===== design/ifmt_ram.sv =====
// ----------------------------------------------------------------------------
// ifmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ifmt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/ipv4_flow_meter_table_core.sv =====
// ----------------------------------------------------------------------------
// ipv4_flow_meter_table_core
// Header bytes: one per cycle while s_axis_tready is high. After the final byte: a check
// state, a scan of the filled entries (one table entry per cycle through the key RAM read
// port and the shared key comparator), then a delivery state that waits for the output register.
// s_axis_tready is low from the final byte until the result is registered.
// Async active-low reset empties the table (fill count to zero), no RAM sweep.
// ----------------------------------------------------------------------------
module ipv4_flow_meter_table_core #(
    parameter int unsigned TABLE_DEPTH = ifmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ifmt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // frame_byte, now_ns
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // slot, byte_total, packet_total, first_seen, zero pad
    output logic [ifmt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [ifmt_pkg::OUTCOME_W-1:0]     m_axis_tuser   // outcome
);

    import ifmt_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned FILL_W = IDX_W + 1;
    localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(TABLE_DEPTH);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_CHECK   = 2'd1;
    localparam logic [1:0] ST_SEARCH  = 2'd2;
    localparam logic [1:0] ST_DELIVER = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [ETYPE_W-1:0]   etype_reg, etype_next;
    logic [IPLEN_W-1:0]   iplen_reg, iplen_next;
    logic [PROTO_W-1:0]   proto_reg, proto_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [PORTS_W-1:0]   ports_reg, ports_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [FILL_W-1:0]    scan_reg, scan_next;
    logic                 cmpv_reg, cmpv_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;

    logic [OUTCOME_W-1:0] res_outcome_reg, res_outcome_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [CNT_W-1:0]     res_bytes_reg, res_bytes_next;
    logic [CNT_W-1:0]     res_pkts_reg, res_pkts_next;
    logic [TIME_W-1:0]    res_first_reg, res_first_next;

    logic                 out_valid_reg, out_valid_next;
    logic [OUTCOME_W-1:0] out_outcome_reg, out_outcome_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [CNT_W-1:0]     out_bytes_reg, out_bytes_next;
    logic [CNT_W-1:0]     out_pkts_reg, out_pkts_next;
    logic [TIME_W-1:0]    out_first_reg, out_first_next;

    logic [BYTE_W-1:0]    in_byte;
    logic [TIME_W-1:0]    in_time;
    logic                 in_fire;
    logic                 l4_proto;
    logic [PORTS_W-1:0]   ports_cur;
    logic [KEY_W-1:0]     key_cur;
    logic                 frame_ok;
    logic                 hit;

    logic                 key_wr_en;
    logic                 cnt_wr_en;
    logic [IDX_W-1:0]     cnt_wr_addr;
    logic [CNTRS_W-1:0]   cnt_wr_data;
    logic [KEY_W-1:0]     key_rd_data;
    logic [CNTRS_W-1:0]   cnt_rd_data;
    logic [CNT_W-1:0]     rd_bytes;
    logic [CNT_W-1:0]     rd_pkts;
    logic [TIME_W-1:0]    rd_first;
    logic [CNT_W-1:0]     upd_bytes;
    logic [CNT_W-1:0]     upd_pkts;

    assign in_byte = s_axis_tdata[BYTE_W-1:0];
    assign in_time = s_axis_tdata[BYTE_W +: TIME_W];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;

    assign l4_proto  = (proto_reg == PROTO_TCP) || (proto_reg == PROTO_UDP);
    assign ports_cur = l4_proto ? ports_reg : '0;
    assign key_cur   = {addr_reg, ports_cur, proto_reg};

    always_comb
    begin
        frame_ok = (pos_reg >= MIN_IP_LEN) && (etype_reg == ETHERTYPE_IPV4);
        if (proto_reg == PROTO_TCP)
        begin
            frame_ok = frame_ok && (pos_reg >= MIN_TCP_LEN);
        end
        else if (proto_reg == PROTO_UDP)
        begin
            frame_ok = frame_ok && (pos_reg >= MIN_UDP_LEN);
        end
    end

    assign rd_bytes  = cnt_rd_data[2*CNT_W +: CNT_W];
    assign rd_pkts   = cnt_rd_data[CNT_W +: CNT_W];
    assign rd_first  = cnt_rd_data[TIME_W-1:0];
    assign upd_bytes = rd_bytes + {{(CNT_W-IPLEN_W){1'b0}}, iplen_reg};
    assign upd_pkts  = rd_pkts + CNT_W'(1);
    assign hit = (state_reg == ST_SEARCH) && cmpv_reg && (key_rd_data == key_cur);

    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        etype_next       = etype_reg;
        iplen_next       = iplen_reg;
        proto_next       = proto_reg;
        addr_next        = addr_reg;
        ports_next       = ports_reg;
        time_next        = time_reg;
        fill_next        = fill_reg;
        scan_next        = scan_reg;
        cmpv_next        = cmpv_reg;
        cmp_idx_next     = cmp_idx_reg;
        res_outcome_next = res_outcome_reg;
        res_slot_next    = res_slot_reg;
        res_bytes_next   = res_bytes_reg;
        res_pkts_next    = res_pkts_reg;
        res_first_next   = res_first_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_outcome_next = out_outcome_reg;
        out_slot_next    = out_slot_reg;
        out_bytes_next   = out_bytes_reg;
        out_pkts_next    = out_pkts_reg;
        out_first_next   = out_first_reg;
        key_wr_en        = 1'b0;
        cnt_wr_en        = 1'b0;
        cnt_wr_addr      = fill_reg[IDX_W-1:0];
        cnt_wr_data      = {{(CNT_W-IPLEN_W){1'b0}}, iplen_reg, CNT_W'(1), time_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (pos_reg < POS_MAX)
                    begin
                        pos_next = pos_reg + POS_W'(1);
                        if (pos_reg inside {POS_ETYPE_HI, POS_ETYPE_LO})
                        begin
                            etype_next = {etype_reg[ETYPE_W-BYTE_W-1:0], in_byte};
                        end
                        else if (pos_reg inside {POS_IPLEN_HI, POS_IPLEN_LO})
                        begin
                            iplen_next = {iplen_reg[IPLEN_W-BYTE_W-1:0], in_byte};
                        end
                        else if (pos_reg == POS_PROTO)
                        begin
                            proto_next = in_byte;
                        end
                        else if (pos_reg inside {[POS_ADDR_FST:POS_ADDR_LST]})
                        begin
                            addr_next = {addr_reg[ADDR_W-BYTE_W-1:0], in_byte};
                        end
                        else if (pos_reg inside {[POS_PORT_FST:POS_PORT_LST]})
                        begin
                            ports_next = {ports_reg[PORTS_W-BYTE_W-1:0], in_byte};
                        end
                    end
                    if (s_axis_tlast)
                    begin
                        time_next  = in_time;
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                scan_next = '0;
                cmpv_next = 1'b0;
                if (frame_ok)
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    res_outcome_next = OUT_NONE;
                    res_slot_next    = '0;
                    res_bytes_next   = '0;
                    res_pkts_next    = '0;
                    res_first_next   = '0;
                    state_next       = ST_DELIVER;
                end
            end

            ST_SEARCH:
            begin
                // Key and counters of entry cmp_idx arrive from the registered RAM read in the cycle after issue.
                if (hit)
                begin
                    cnt_wr_en        = 1'b1;
                    cnt_wr_addr      = cmp_idx_reg;
                    cnt_wr_data      = {upd_bytes, upd_pkts, rd_first};
                    res_outcome_next = OUT_UPDATE;
                    res_slot_next    = SLOT_W'(cmp_idx_reg);
                    res_bytes_next   = upd_bytes;
                    res_pkts_next    = upd_pkts;
                    res_first_next   = rd_first;
                    cmpv_next        = 1'b0;
                    state_next       = ST_DELIVER;
                end
                else if (scan_reg < fill_reg)
                begin
                    cmpv_next    = 1'b1;
                    cmp_idx_next = scan_reg[IDX_W-1:0];
                    scan_next    = scan_reg + FILL_W'(1);
                end
                else if (cmpv_reg)
                begin
                    cmpv_next = 1'b0;
                end
                else if (fill_reg < DEPTH_FILL)
                begin
                    // entries are never freed, so the lowest free slot is the fill count
                    key_wr_en        = 1'b1;
                    cnt_wr_en        = 1'b1;
                    res_outcome_next = OUT_INSERT;
                    res_slot_next    = SLOT_W'(fill_reg[IDX_W-1:0]);
                    res_bytes_next   = {{(CNT_W-IPLEN_W){1'b0}}, iplen_reg};
                    res_pkts_next    = CNT_W'(1);
                    res_first_next   = time_reg;
                    fill_next        = fill_reg + FILL_W'(1);
                    state_next       = ST_DELIVER;
                end
                else
                begin
                    res_outcome_next = OUT_FULL;
                    res_slot_next    = '0;
                    res_bytes_next   = '0;
                    res_pkts_next    = '0;
                    res_first_next   = '0;
                    state_next       = ST_DELIVER;
                end
            end

            ST_DELIVER:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_outcome_next = res_outcome_reg;
                    out_slot_next    = res_slot_reg;
                    out_bytes_next   = res_bytes_reg;
                    out_pkts_next    = res_pkts_reg;
                    out_first_next   = res_first_reg;
                    pos_next         = '0;
                    etype_next       = '0;
                    iplen_next       = '0;
                    proto_next       = '0;
                    addr_next        = '0;
                    ports_next       = '0;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            etype_reg     <= '0;
            iplen_reg     <= '0;
            proto_reg     <= '0;
            addr_reg      <= '0;
            ports_reg     <= '0;
            fill_reg      <= '0;
            scan_reg      <= '0;
            cmpv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            etype_reg     <= etype_next;
            iplen_reg     <= iplen_next;
            proto_reg     <= proto_next;
            addr_reg      <= addr_next;
            ports_reg     <= ports_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            cmpv_reg      <= cmpv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg        <= time_next;
        cmp_idx_reg     <= cmp_idx_next;
        res_outcome_reg <= res_outcome_next;
        res_slot_reg    <= res_slot_next;
        res_bytes_reg   <= res_bytes_next;
        res_pkts_reg    <= res_pkts_next;
        res_first_reg   <= res_first_next;
        out_outcome_reg <= out_outcome_next;
        out_slot_reg    <= out_slot_next;
        out_bytes_reg   <= out_bytes_next;
        out_pkts_reg    <= out_pkts_next;
        out_first_reg   <= out_first_next;
    end

    ifmt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (fill_reg[IDX_W-1:0]),
        .wr_data (key_cur),
        .rd_addr (scan_reg[IDX_W-1:0]),
        .rd_data (key_rd_data)
    );

    ifmt_ram #(
        .WIDTH (CNTRS_W),
        .DEPTH (TABLE_DEPTH)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_addr (scan_reg[IDX_W-1:0]),
        .rd_data (cnt_rd_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_outcome_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_first_reg, out_pkts_reg,
                            out_bytes_reg, out_slot_reg};

    // Assertions

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_FILL)
        else $error("fill count beyond table depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_next != fill_reg) |-> (fill_next == fill_reg + FILL_W'(1)))
        else $error("fill count moved by more than one entry");

    a_cmp_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmpv_reg |-> ({1'b0, cmp_idx_reg} < fill_reg))
        else $error("compare on an entry that was never filled");

    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken while a frame lookup is pending");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == OUT_NONE || m_axis_tuser == OUT_FULL))
        |-> (m_axis_tdata == '0))
        else $error("uncounted result carries nonzero fields");

endmodule

// ===== dv/tb_ipv4_flow_meter_table_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv4_flow_meter_table_core
// Streams Ethernet frames byte by byte into the flow meter and checks every
// per-frame result against a local flow-table predictor. Covers short and
// non-IPv4 frames, TCP/UDP/other protocols, long frames, hits and inserts.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_ipv4_flow_meter_table_core;

    import ifmt_pkg::*;

    localparam int FLOW_SLOTS  = TABLE_DEPTH_DEF;
    localparam int QUIET_LIMIT = 20000;
    localparam int RANDOM_BYTES = 1160;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
    } flow_t;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [SLOT_W-1:0]    slot;
        logic [CNT_W-1:0]     byte_total;
        logic [CNT_W-1:0]     packet_total;
        logic [TIME_W-1:0]    first_seen;
    } meter_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // frame_byte, now_ns
    logic                   s_axis_tlast;   // frame_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // slot, byte_total, packet_total, first_seen, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUTCOME_W-1:0]   m_axis_tuser;   // outcome

    // predictor: per-frame capture
    logic [POS_W-1:0]   frm_pos;
    logic [ETYPE_W-1:0] frm_etype;
    logic [IPLEN_W-1:0] frm_iplen;
    logic [PROTO_W-1:0] frm_proto;
    logic [ADDR_W-1:0]  frm_addrs;
    logic [PORTS_W-1:0] frm_ports;

    // predictor: flow table
    logic               tbl_valid [FLOW_SLOTS];
    logic [ADDR_W-1:0]  tbl_addrs [FLOW_SLOTS];
    logic [39:0]        tbl_key   [FLOW_SLOTS];
    logic [CNT_W-1:0]   tbl_bytes [FLOW_SLOTS];
    logic [CNT_W-1:0]   tbl_pkts  [FLOW_SLOTS];
    logic [TIME_W-1:0]  tbl_start [FLOW_SLOTS];
    int                 tbl_fill;

    meter_result_t      flow_results_q [$];
    int                 mismatches;
    bit                 gaps_on;
    int                 quiet_cycles;
    flow_t              flow_pool [12];

    ipv4_flow_meter_table_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Header capture on every byte; flow table lookup and update on the final byte of each frame
    task automatic meter_take_byte(input logic [7:0] b, input logic last,
                                   input logic [TIME_W-1:0] stamp);
        logic               ok;
        logic [PORTS_W-1:0] ports;
        logic [39:0]        key;
        int                 hit_idx;
        int                 free_idx;
        meter_result_t      r;
        if (frm_pos < POS_MAX)
        begin
            if (frm_pos == POS_ETYPE_HI || frm_pos == POS_ETYPE_LO)
                frm_etype = {frm_etype[7:0], b};
            else if (frm_pos == POS_IPLEN_HI || frm_pos == POS_IPLEN_LO)
                frm_iplen = {frm_iplen[7:0], b};
            else if (frm_pos == POS_PROTO)
                frm_proto = b;
            else if (frm_pos >= POS_ADDR_FST && frm_pos <= POS_ADDR_LST)
                frm_addrs = {frm_addrs[ADDR_W-9:0], b};
            else if (frm_pos >= POS_PORT_FST && frm_pos <= POS_PORT_LST)
                frm_ports = {frm_ports[PORTS_W-9:0], b};
            frm_pos = frm_pos + 1'b1;
        end
        if (!last)
            return;

        ok    = (frm_pos >= MIN_IP_LEN) && (frm_etype == ETHERTYPE_IPV4);
        ports = '0;
        if (ok && frm_proto == PROTO_TCP)
        begin
            ok    = frm_pos >= MIN_TCP_LEN;
            ports = frm_ports;
        end
        else if (ok && frm_proto == PROTO_UDP)
        begin
            ok    = frm_pos >= MIN_UDP_LEN;
            ports = frm_ports;
        end

        r = '0;
        r.outcome = OUT_NONE;
        if (ok)
        begin
            key      = {ports, frm_proto};
            hit_idx  = -1;
            free_idx = -1;
            for (int i = 0; i < FLOW_SLOTS; i++)
            begin
                if (tbl_valid[i])
                begin
                    if (hit_idx < 0 && tbl_addrs[i] == frm_addrs && tbl_key[i] == key)
                        hit_idx = i;
                end
                else if (free_idx < 0)
                    free_idx = i;
            end
            if (hit_idx >= 0)
            begin
                tbl_bytes[hit_idx] = tbl_bytes[hit_idx] + frm_iplen;
                tbl_pkts[hit_idx]  = tbl_pkts[hit_idx] + 1;
                r.outcome      = OUT_UPDATE;
                r.slot         = hit_idx[SLOT_W-1:0];
                r.byte_total   = tbl_bytes[hit_idx];
                r.packet_total = tbl_pkts[hit_idx];
                r.first_seen   = tbl_start[hit_idx];
            end
            else if (free_idx >= 0)
            begin
                tbl_valid[free_idx] = 1'b1;
                tbl_addrs[free_idx] = frm_addrs;
                tbl_key[free_idx]   = key;
                tbl_bytes[free_idx] = frm_iplen;
                tbl_pkts[free_idx]  = 1;
                tbl_start[free_idx] = stamp;
                tbl_fill++;
                r.outcome      = OUT_INSERT;
                r.slot         = free_idx[SLOT_W-1:0];
                r.byte_total   = frm_iplen;
                r.packet_total = 1;
                r.first_seen   = stamp;
            end
            else
                r.outcome = OUT_FULL;
        end
        flow_results_q.push_back(r);

        frm_pos   = '0;
        frm_etype = '0;
        frm_iplen = '0;
        frm_proto = '0;
        frm_addrs = '0;
        frm_ports = '0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic [TIME_W-1:0] stamp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stamp, b};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        meter_take_byte(b, last, stamp);
    endtask

    function automatic logic [7:0] header_byte(flow_t f, logic [ETYPE_W-1:0] etype,
                                               logic [IPLEN_W-1:0] iplen, int p);
        logic [ADDR_W-1:0]  addrs;
        logic [PORTS_W-1:0] ports;
        addrs = {f.src, f.dst};
        ports = {f.sport, f.dport};
        if (p == POS_ETYPE_HI)
            return etype[15:8];
        if (p == POS_ETYPE_LO)
            return etype[7:0];
        if (p == POS_IPLEN_HI)
            return iplen[15:8];
        if (p == POS_IPLEN_LO)
            return iplen[7:0];
        if (p == POS_PROTO)
            return f.proto;
        if (p >= POS_ADDR_FST && p <= POS_ADDR_LST)
            return addrs[8 * (POS_ADDR_LST - p) +: 8];
        if (p >= POS_PORT_FST && p <= POS_PORT_LST)
            return ports[8 * (POS_PORT_LST - p) +: 8];
        return 8'($urandom);
    endfunction

    // Non-final bytes carry random timestamps; only the final one counts
    task automatic send_frame(input flow_t f, input logic [ETYPE_W-1:0] etype,
                              input logic [IPLEN_W-1:0] iplen, input int nbytes,
                              input logic [TIME_W-1:0] stamp);
        for (int p = 0; p < nbytes; p++)
        begin
            if (p == nbytes - 1)
                send_byte(header_byte(f, etype, iplen, p), 1'b1, stamp);
            else
                send_byte(header_byte(f, etype, iplen, p), 1'b0, {$urandom, $urandom});
        end
    endtask

    function automatic flow_t random_flow(logic [7:0] proto);
        flow_t f;
        f.src   = $urandom;
        f.dst   = $urandom;
        f.sport = 16'($urandom);
        f.dport = 16'($urandom);
        f.proto = proto;
        return f;
    endfunction

    function automatic int min_len(logic [7:0] proto);
        if (proto == PROTO_TCP)
            return MIN_TCP_LEN;
        if (proto == PROTO_UDP)
            return MIN_UDP_LEN;
        return MIN_IP_LEN;
    endfunction

    function automatic logic [7:0] random_proto();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return PROTO_TCP;
        if (r < 8)
            return PROTO_UDP;
        return 8'($urandom);
    endfunction

    task automatic test_directed_frames();
        flow_t udp_a;
        flow_t udp_rev;
        flow_t tcp_a;
        flow_t icmp_a;
        flow_t ones_f;
        flow_t zero_f;
        udp_a  = '{32'hC0A8_0001, 32'hC0A8_0002, 16'd1234, 16'd53, PROTO_UDP};
        tcp_a  = '{32'h0A01_0203, 32'h0A04_0506, 16'd40000, 16'd443, PROTO_TCP};
        icmp_a = '{32'hAC10_0001, 32'hAC10_00FE, 16'h1111, 16'h2222, 8'd1};
        ones_f = '1;
        zero_f = '0;
        udp_rev = udp_a;
        udp_rev.sport = udp_a.dport;
        udp_rev.dport = udp_a.sport;
        gaps_on = 1'b1;

        send_frame(udp_a, ETHERTYPE_IPV4, 16'h0000, MIN_UDP_LEN, '0);
        send_frame(udp_a, ETHERTYPE_IPV4, 16'hFFFF, 60, '1);
        send_frame(udp_a, ETHERTYPE_IPV4, 16'h0040, MIN_UDP_LEN - 1, '1);
        send_frame(tcp_a, ETHERTYPE_IPV4, 16'h05DC, MIN_TCP_LEN - 1, 64'd5);
        send_frame(tcp_a, ETHERTYPE_IPV4, 16'h05DC, MIN_TCP_LEN, 64'd6);
        // ports of other protocols are ignored: second frame hits the first
        send_frame(icmp_a, ETHERTYPE_IPV4, 16'h0054, MIN_IP_LEN, 64'h8000_0000_0000_0000);
        icmp_a.sport = 16'hABCD;
        icmp_a.dport = 16'h0F0F;
        send_frame(icmp_a, ETHERTYPE_IPV4, 16'h0054, 48, 64'd7);
        send_frame(icmp_a, ETHERTYPE_IPV4, 16'h0054, MIN_IP_LEN - 1, 64'd8);
        send_frame(udp_a, 16'h86DD, 16'h0100, 60, 64'd9);
        send_frame(udp_a, 16'h0801, 16'h0100, 60, 64'd10);
        // long frame: bytes past the saturation point are dropped
        send_frame(tcp_a, ETHERTYPE_IPV4, 16'h0200, 120, 64'd11);
        send_frame(udp_a, ETHERTYPE_IPV4, 16'h0010, 1, 64'd12);
        send_frame(udp_a, ETHERTYPE_IPV4, 16'h0010, 13, 64'd13);
        send_frame(ones_f, ETHERTYPE_IPV4, 16'hFFFF, 63, '1);
        send_frame(zero_f, ETHERTYPE_IPV4, 16'h0000, MIN_IP_LEN, '0);
        send_frame(udp_rev, ETHERTYPE_IPV4, 16'h0033, MIN_UDP_LEN, 64'd14);
        send_frame(ones_f, ETHERTYPE_IPV4, 16'h0001, MIN_IP_LEN, 64'd15);
    endtask

    task automatic test_random_traffic();
        int sent;
        int frame_no;
        int r;
        int idx;
        int nbytes;
        flow_t f;
        logic [ETYPE_W-1:0] etype;
        for (int i = 0; i < 12; i++)
            flow_pool[i] = random_flow(random_proto());
        sent     = 0;
        frame_no = 0;
        while (sent < RANDOM_BYTES)
        begin
            gaps_on = ((frame_no / 8) % 3) != 2;
            idx = $urandom_range(0, 11);
            f   = flow_pool[idx];
            r   = $urandom_range(0, 99);
            if (r < 75)
            begin
                nbytes = min_len(f.proto) + $urandom_range(0, 20);
                send_frame(f, ETHERTYPE_IPV4, 16'($urandom), nbytes, {$urandom, $urandom});
            end
            else if (r < 85)
            begin
                nbytes = $urandom_range(1, min_len(f.proto) - 1);
                send_frame(f, ETHERTYPE_IPV4, 16'($urandom), nbytes, {$urandom, $urandom});
            end
            else if (r < 95)
            begin
                etype = 16'($urandom);
                if (etype == ETHERTYPE_IPV4)
                    etype = ~etype;
                nbytes = $urandom_range(14, 80);
                send_frame(f, etype, 16'($urandom), nbytes, {$urandom, $urandom});
            end
            else
            begin
                nbytes = $urandom_range(1, 90);
                send_frame(random_flow(8'($urandom)), 16'($urandom), 16'($urandom),
                           nbytes, {$urandom, $urandom});
            end
            sent += nbytes;
            frame_no++;
        end
    endtask

    // result checker and output-side backpressure
    initial
    begin
        int            stall_left;
        meter_result_t got;
        meter_result_t want;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.outcome      = m_axis_tuser;
                got.slot         = m_axis_tdata[SLOT_W-1:0];
                got.byte_total   = m_axis_tdata[SLOT_W +: CNT_W];
                got.packet_total = m_axis_tdata[SLOT_W + CNT_W +: CNT_W];
                got.first_seen   = m_axis_tdata[SLOT_W + 2 * CNT_W +: TIME_W];
                if (flow_results_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with none expected: outcome %0d slot %0d",
                                 $realtime, got.outcome, got.slot);
                end
                else
                begin
                    want = flow_results_q.pop_front();
                    if (got.outcome !== want.outcome || got.slot !== want.slot ||
                        got.byte_total !== want.byte_total ||
                        got.packet_total !== want.packet_total ||
                        got.first_seen !== want.first_seen)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch exp outcome %0d slot %0d bytes %0h pkts %0h first %0h",
                                     $realtime, want.outcome, want.slot, want.byte_total,
                                     want.packet_total, want.first_seen);
                            $display("%0t:          got outcome %0d slot %0d bytes %0h pkts %0h first %0h",
                                     $realtime, got.outcome, got.slot, got.byte_total,
                                     got.packet_total, got.first_seen);
                        end
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (gaps_on && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    // watchdog: no transaction on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        mismatches     = 0;
        gaps_on        = 1'b1;
        tbl_fill       = 0;
        frm_pos        = '0;
        frm_etype      = '0;
        frm_iplen      = '0;
        frm_proto      = '0;
        frm_addrs      = '0;
        frm_ports      = '0;
        for (int i = 0; i < FLOW_SLOTS; i++)
            tbl_valid[i] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (flow_results_q.size() != 0)
            @(posedge clk);
        // a stray result would need at most one full table scan
        repeat (FLOW_SLOTS + 64) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
